>>> hdl/static_contact_resolver_2d_assert.svh
// assertion macros for the contact resolver
`ifndef STATIC_CONTACT_RESOLVER_2D_ASSERT_SVH
`define STATIC_CONTACT_RESOLVER_2D_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on aclk, off during reset
`define SCR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("contact resolver assertion failed");
// next-cycle implication, clocked on aclk, off during reset
`define SCR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("contact resolver assertion failed");
`else
`define SCR_ASSERT_IMP(label, ante, cons)
`define SCR_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> hdl/scr_pkg.sv
// types, constants and helper functions of the contact resolver
package scr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NW        = FRAC_BITS + 2;
    localparam int SQ_STEPS  = 34;
    localparam int DV_STEPS  = FRAC_BITS + 1;

    localparam logic signed [NW-1:0] ONE    = NW'(1 << FRAC_BITS);
    localparam logic signed [NW-1:0] GND_TH = NW'((11 << FRAC_BITS) / 20);
    localparam logic [16:0]          R_ONE  = 17'd65536;

    // pair kinds
    localparam logic [1:0] CMD_BOX_BOX = 2'd0;
    localparam logic [1:0] CMD_BOX_CIR = 2'd1;
    localparam logic [1:0] CMD_CIR_BOX = 2'd2;
    localparam logic [1:0] CMD_CIR_CIR = 2'd3;

    // resolution modes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_DIRECT = 2'd1;
    localparam logic [1:0] MODE_NRM_CB = 2'd2;
    localparam logic [1:0] MODE_NRM_CC = 2'd3;

    // face order for least penetration
    localparam logic [1:0] AX_LEFT  = 2'd0;
    localparam logic [1:0] AX_RIGHT = 2'd1;
    localparam logic [1:0] AX_DOWN  = 2'd2;
    localparam logic [1:0] AX_UP    = 2'd3;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [1:0]               mode;
        logic signed [31:0]       vx;
        logic signed [31:0]       vy;
        logic [16:0]              e;
        logic signed [35:0]       ux;
        logic signed [35:0]       uy;
        logic signed [35:0]       rad;
        logic signed [35:0]       f0;
        logic signed [35:0]       f1;
        logic signed [35:0]       f2;
        logic signed [35:0]       f3;
        logic                     allpos;
        logic [1:0]               axis;
        logic signed [35:0]       m;
        logic [33:0]              ax;
        logic [33:0]              ay;
        logic [33:0]              ar;
        logic [67:0]              sx;
        logic [67:0]              sy;
        logic [67:0]              sr;
        logic [67:0]              d2;
        logic [33:0]              root;
        logic [37:0]              srem;
        logic [FRAC_BITS:0]       qx;
        logic [FRAC_BITS:0]       qy;
        logic [35:0]              rx;
        logic [35:0]              ry;
        logic                     hit;
        logic                     refl;
        logic                     zvx;
        logic                     zvy;
        logic                     gnd;
        logic signed [39:0]       dx;
        logic signed [39:0]       dy;
        logic signed [NW-1:0]     nx;
        logic signed [NW-1:0]     ny;
        logic signed [35:0]       pen;
        logic signed [39:0]       vn;
        logic signed [39:0]       tt;
        logic signed [63:0]       p0;
        logic signed [63:0]       p1;
        logic signed [63:0]       p2;
        logic signed [63:0]       p3;
    } item_t;

    // shift right with truncation toward zero
    function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v, input int sh);
        logic [63:0] mg;
        mg = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        mg = mg >> sh;
        return v[63] ? $signed(64'd0 - mg) : $signed(mg);
    endfunction

    // saturate to 32 bits signed
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // magnitude of a 36-bit signed value
    function automatic logic [33:0] mag34(input logic signed [35:0] v);
        logic [35:0] mg;
        mg = v[35] ? (36'd0 - 36'(v)) : 36'(v);
        return mg[33:0];
    endfunction

endpackage

>>> hdl/static_contact_resolver_2d.sv
// contact resolver top level: front end, square root, divider and reflection pipeline
//
// Input words arrive on the s_ channel: s_tuser carries the pair kind, s_tdata the
// two bodies, the velocity and the restitution. One result word per input word
// leaves on the m_ channel with the hit flag, correction, new velocity and
// grounded flag. Non-overlapping pairs give an all-zero result word.
// The block is a 62-stage pipeline: four front-end stages (clamp, magnitudes,
// squares, case decision), 34 stages of the bit-per-stage square root, 17 stages
// of the restoring divider that forms the contact normal, and seven stages for
// the signed normal, the correction and the reflected velocity, the last being
// the output register. One word is accepted in every cycle in which the pipeline
// is not frozen by a stalled receiver.
// A stalled receiver with a word waiting in the output register freezes the whole
// pipeline and drops s_tready in the same cycle, so no word is lost or repeated.
// Reset clears all stage valid bits; the data registers are not reset.
module static_contact_resolver_2d
    import scr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dyn_x0, dyn_y0, dyn_x1, dyn_y1, st_x0, st_y0, st_x1, st_y1, vel_x, vel_y,
    // restitution (17), zero fill
    input  logic [343:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit, delta_x, delta_y, new_vel_x, new_vel_y, grounded, zero fill
    output logic [135:0] m_tdata
);

`include "static_contact_resolver_2d_assert.svh"

    localparam int NST = 4 + SQ_STEPS + DV_STEPS + 7;

    logic           pipe_en;
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;

    item_t f1_reg, f2_reg, f3_reg, f4_reg;
    item_t f1_next, f2_next, f3_next, f4_next;
    item_t sq_reg [0:SQ_STEPS-1];
    item_t dv_reg [0:DV_STEPS-1];
    item_t b1_reg, b2_reg, b3_reg, b4_reg, b5_reg, b6_reg;
    item_t b1_next, b2_next, b3_next, b4_next, b5_next, b6_next;

    logic               out_hit_reg, out_hit_next;
    logic               out_gnd_reg, out_gnd_next;
    logic signed [31:0] out_dx_reg, out_dx_next;
    logic signed [31:0] out_dy_reg, out_dy_next;
    logic signed [31:0] out_vx_reg, out_vx_next;
    logic signed [31:0] out_vy_reg, out_vy_next;

    // global advance: the output register is free or being emptied
    assign pipe_en  = !vld_reg[NST-1] || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {6'd0, out_gnd_reg, out_vy_reg, out_vx_reg, out_dy_reg, out_dx_reg,
                       out_hit_reg};

    // valid bits
    assign vld_next = {vld_reg[NST-2:0], s_tvalid};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= vld_next;
        end
    end

    // front stage 1: unpack, clamp circle centre to box, face distances
    always_comb begin
        logic signed [35:0] d0, d1, d2, d3, s0, s1, s2, s3;
        logic signed [35:0] cx, cy, cr, b0, b1, b2, b3, qx, qy;
        logic               neg;
        d0 = 36'($signed(s_tdata[31:0]));
        d1 = 36'($signed(s_tdata[63:32]));
        d2 = 36'($signed(s_tdata[95:64]));
        d3 = 36'($signed(s_tdata[127:96]));
        s0 = 36'($signed(s_tdata[159:128]));
        s1 = 36'($signed(s_tdata[191:160]));
        s2 = 36'($signed(s_tdata[223:192]));
        s3 = 36'($signed(s_tdata[255:224]));
        f1_next     = '0;
        f1_next.cmd = s_tuser;
        f1_next.vx  = $signed(s_tdata[287:256]);
        f1_next.vy  = $signed(s_tdata[319:288]);
        f1_next.e   = (s_tdata[336:320] > R_ONE) ? R_ONE : s_tdata[336:320];
        neg = (s_tuser == CMD_BOX_CIR);
        cx  = neg ? s0 : d0;
        cy  = neg ? s1 : d1;
        cr  = neg ? s2 : d2;
        b0  = neg ? d0 : s0;
        b1  = neg ? d1 : s1;
        b2  = neg ? d2 : s2;
        b3  = neg ? d3 : s3;
        qx  = (cx < b0) ? b0 : cx;
        qx  = (qx > b2) ? b2 : qx;
        qy  = (cy < b1) ? b1 : cy;
        qy  = (qy > b3) ? b3 : qy;
        case (s_tuser)
            CMD_BOX_BOX: begin
                f1_next.f0 = d2 - s0;
                f1_next.f1 = s2 - d0;
                f1_next.f2 = d3 - s1;
                f1_next.f3 = s3 - d1;
            end
            CMD_CIR_CIR: begin
                f1_next.ux  = d0 - s0;
                f1_next.uy  = d1 - s1;
                f1_next.rad = d2 + s2;
            end
            default: begin
                f1_next.ux  = neg ? (qx - cx) : (cx - qx);
                f1_next.uy  = neg ? (qy - cy) : (cy - qy);
                f1_next.rad = cr;
                f1_next.f0  = cx - b0;
                f1_next.f1  = b2 - cx;
                f1_next.f2  = cy - b1;
                f1_next.f3  = b3 - cy;
            end
        endcase
    end

    // front stage 2: magnitudes and least penetration face
    always_comb begin
        f2_next        = f1_reg;
        f2_next.ax     = mag34(f1_reg.ux);
        f2_next.ay     = mag34(f1_reg.uy);
        f2_next.ar     = mag34(f1_reg.rad);
        f2_next.allpos = (f1_reg.f0 > 0) && (f1_reg.f1 > 0) && (f1_reg.f2 > 0)
                         && (f1_reg.f3 > 0);
        f2_next.m      = f1_reg.f0;
        f2_next.axis   = AX_LEFT;
        if (f1_reg.f1 < f2_next.m) begin
            f2_next.m    = f1_reg.f1;
            f2_next.axis = AX_RIGHT;
        end
        if (f1_reg.f2 < f2_next.m) begin
            f2_next.m    = f1_reg.f2;
            f2_next.axis = AX_DOWN;
        end
        if (f1_reg.f3 < f2_next.m) begin
            f2_next.m    = f1_reg.f3;
            f2_next.axis = AX_UP;
        end
    end

    // front stage 3: squares and divider start remainders
    always_comb begin
        f3_next    = f2_reg;
        f3_next.sx = 68'(f2_reg.ax) * 68'(f2_reg.ax);
        f3_next.sy = 68'(f2_reg.ay) * 68'(f2_reg.ay);
        f3_next.sr = 68'(f2_reg.ar) * 68'(f2_reg.ar);
        f3_next.rx = 36'(f2_reg.ax >> 1);
        f3_next.ry = 36'(f2_reg.ay >> 1);
    end

    // front stage 4: squared distance and case decision
    always_comb begin
        logic signed [35:0] pin;
        f4_next      = f3_reg;
        f4_next.d2   = f3_reg.sx + f3_reg.sy;
        f4_next.root = '0;
        f4_next.srem = '0;
        f4_next.qx   = '0;
        f4_next.qy   = '0;
        f4_next.mode = MODE_NONE;
        f4_next.hit  = 1'b0;
        f4_next.refl = 1'b0;
        f4_next.zvx  = 1'b0;
        f4_next.zvy  = 1'b0;
        f4_next.gnd  = 1'b0;
        f4_next.dx   = '0;
        f4_next.dy   = '0;
        f4_next.nx   = '0;
        f4_next.ny   = '0;
        pin = f3_reg.rad - f3_reg.m;
        case (f3_reg.cmd)
            CMD_BOX_BOX: begin
                if (f3_reg.allpos) begin
                    f4_next.mode = MODE_DIRECT;
                    f4_next.hit  = 1'b1;
                    f4_next.refl = 1'b1;
                    case (f3_reg.axis)
                        AX_UP: begin
                            f4_next.dy  = 40'(f3_reg.f3);
                            f4_next.ny  = ONE;
                            f4_next.gnd = 1'b1;
                        end
                        AX_DOWN: begin
                            f4_next.dy = -40'(f3_reg.f2);
                            f4_next.ny = -ONE;
                        end
                        AX_LEFT: begin
                            f4_next.dx = -40'(f3_reg.f0);
                            f4_next.nx = -ONE;
                        end
                        default: begin
                            f4_next.dx = 40'(f3_reg.f1);
                            f4_next.nx = ONE;
                        end
                    endcase
                end
            end
            CMD_CIR_CIR: begin
                if (f4_next.d2 <= f3_reg.sr) begin
                    if (f4_next.d2 == '0) begin
                        f4_next.mode = MODE_DIRECT;
                        f4_next.hit  = 1'b1;
                        f4_next.refl = 1'b1;
                        f4_next.dx   = 40'(shr_tz(64'(f3_reg.rad), 1));
                        f4_next.nx   = ONE;
                    end else begin
                        f4_next.mode = MODE_NRM_CC;
                    end
                end
            end
            default: begin
                if (f4_next.d2 != '0) begin
                    f4_next.mode = MODE_NRM_CB;
                end else if (f3_reg.m < f3_reg.rad) begin
                    f4_next.mode = MODE_DIRECT;
                    f4_next.hit  = 1'b1;
                    case (f3_reg.axis)
                        AX_LEFT: begin
                            f4_next.dx  = 40'(pin);
                            f4_next.zvx = 1'b1;
                        end
                        AX_RIGHT: begin
                            f4_next.dx  = -40'(pin);
                            f4_next.zvx = 1'b1;
                        end
                        AX_DOWN: begin
                            f4_next.dy  = 40'(pin);
                            f4_next.zvy = 1'b1;
                            f4_next.gnd = 1'b1;
                        end
                        default: begin
                            f4_next.dy  = -40'(pin);
                            f4_next.zvy = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    // front stage registers
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
            f4_reg <= f4_next;
        end
    end

    // square root, one result bit per stage
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        localparam int BI = SQ_STEPS - 1 - g;
        item_t       src;
        item_t       nxt;
        logic [37:0] trem;
        logic [37:0] trial;
        if (g == 0) begin : g_first
            assign src = f4_reg;
        end else begin : g_rest
            assign src = sq_reg[g-1];
        end
        always_comb begin
            nxt   = src;
            trem  = {src.srem[35:0], src.d2[2*BI+1:2*BI]};
            trial = {2'b00, src.root, 2'b01};
            if (trem >= trial) begin
                nxt.srem = trem - trial;
                nxt.root = {src.root[32:0], 1'b1};
            end else begin
                nxt.srem = trem;
                nxt.root = {src.root[32:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                sq_reg[g] <= nxt;
            end
        end
    end

    // normal divider, one quotient bit per stage for both axes
    for (genvar g = 0; g < DV_STEPS; g++) begin : g_dv
        localparam int QI = FRAC_BITS - g;
        item_t       src;
        item_t       nxt;
        logic [36:0] tx;
        logic [36:0] ty;
        logic [36:0] dv;
        if (g == 0) begin : g_first
            assign src = sq_reg[SQ_STEPS-1];
        end else begin : g_rest
            assign src = dv_reg[g-1];
        end
        always_comb begin
            nxt = src;
            dv  = {3'b000, src.root};
            tx  = {src.rx, (QI == FRAC_BITS) ? src.ax[0] : 1'b0};
            ty  = {src.ry, (QI == FRAC_BITS) ? src.ay[0] : 1'b0};
            if (tx >= dv) begin
                nxt.rx     = 36'(tx - dv);
                nxt.qx[QI] = 1'b1;
            end else begin
                nxt.rx     = tx[35:0];
                nxt.qx[QI] = 1'b0;
            end
            if (ty >= dv) begin
                nxt.ry     = 36'(ty - dv);
                nxt.qy[QI] = 1'b1;
            end else begin
                nxt.ry     = ty[35:0];
                nxt.qy[QI] = 1'b0;
            end
        end
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                dv_reg[g] <= nxt;
            end
        end
    end

    // back stage 1: signed normal, penetration, hit and grounding
    always_comb begin
        logic signed [NW-1:0] qxs, qys;
        b1_next = dv_reg[DV_STEPS-1];
        qxs = $signed({1'b0, b1_next.qx});
        qys = $signed({1'b0, b1_next.qy});
        b1_next.pen = b1_next.rad - $signed({2'b00, b1_next.root});
        if (b1_next.mode == MODE_NRM_CB || b1_next.mode == MODE_NRM_CC) begin
            b1_next.nx   = b1_next.ux[35] ? -qxs : qxs;
            b1_next.ny   = b1_next.uy[35] ? -qys : qys;
            b1_next.hit  = (b1_next.mode == MODE_NRM_CC) || (b1_next.pen > 0);
            b1_next.refl = 1'b1;
            b1_next.gnd  = b1_next.ny > GND_TH;
        end
    end

    // back stage 2: correction and normal velocity products
    always_comb begin
        b2_next    = b1_reg;
        b2_next.p0 = 64'(b1_reg.nx) * 64'(b1_reg.pen);
        b2_next.p1 = 64'(b1_reg.ny) * 64'(b1_reg.pen);
        b2_next.p2 = 64'(b1_reg.vx) * 64'(b1_reg.nx);
        b2_next.p3 = 64'(b1_reg.vy) * 64'(b1_reg.ny);
    end

    // back stage 3: scale correction, normal velocity
    always_comb begin
        b3_next = b2_reg;
        if (b2_reg.mode == MODE_NRM_CB || b2_reg.mode == MODE_NRM_CC) begin
            b3_next.dx = 40'(shr_tz(b2_reg.p0, FRAC_BITS));
            b3_next.dy = 40'(shr_tz(b2_reg.p1, FRAC_BITS));
        end
        b3_next.vn = 40'(shr_tz(b2_reg.p2 + b2_reg.p3, FRAC_BITS));
    end

    // back stage 4: bounce factor product
    always_comb begin
        b4_next    = b3_reg;
        b4_next.p0 = 64'(b3_reg.vn) * 64'($signed({1'b0, 18'(R_ONE) + 18'(b3_reg.e)}));
    end

    // back stage 5: scale bounce impulse
    always_comb begin
        b5_next    = b4_reg;
        b5_next.tt = 40'(shr_tz(b4_reg.p0, 16));
    end

    // back stage 6: impulse along the normal
    always_comb begin
        b6_next    = b5_reg;
        b6_next.p0 = 64'(b5_reg.tt) * 64'(b5_reg.nx);
        b6_next.p1 = 64'(b5_reg.tt) * 64'(b5_reg.ny);
    end

    // output stage: apply impulse, saturate, clear on miss
    always_comb begin
        logic signed [63:0] vxw, vyw;
        vxw = 64'(b6_reg.vx);
        vyw = 64'(b6_reg.vy);
        if (b6_reg.refl && b6_reg.vn < 0) begin
            vxw = vxw - shr_tz(b6_reg.p0, FRAC_BITS);
            vyw = vyw - shr_tz(b6_reg.p1, FRAC_BITS);
        end
        if (b6_reg.zvx) begin
            vxw = '0;
        end
        if (b6_reg.zvy) begin
            vyw = '0;
        end
        out_hit_next = b6_reg.hit;
        out_gnd_next = b6_reg.hit && b6_reg.gnd;
        out_dx_next  = b6_reg.hit ? sat32(64'(b6_reg.dx)) : '0;
        out_dy_next  = b6_reg.hit ? sat32(64'(b6_reg.dy)) : '0;
        out_vx_next  = b6_reg.hit ? sat32(vxw) : '0;
        out_vy_next  = b6_reg.hit ? sat32(vyw) : '0;
    end

    // back stage and output registers
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            b1_reg      <= b1_next;
            b2_reg      <= b2_next;
            b3_reg      <= b3_next;
            b4_reg      <= b4_next;
            b5_reg      <= b5_next;
            b6_reg      <= b6_next;
            out_hit_reg <= out_hit_next;
            out_gnd_reg <= out_gnd_next;
            out_dx_reg  <= out_dx_next;
            out_dy_reg  <= out_dy_next;
            out_vx_reg  <= out_vx_next;
            out_vy_reg  <= out_vy_next;
        end
    end

    // checks
    `SCR_ASSERT_IMP(a_miss_zero, m_tvalid && !out_hit_reg,
        out_dx_reg == 0 && out_dy_reg == 0 && out_vx_reg == 0 && out_vy_reg == 0)
    `SCR_ASSERT_IMP(a_gnd_hit, m_tvalid && out_gnd_reg, out_hit_reg)
    `SCR_ASSERT_NXT(a_stall_hold, !pipe_en, $stable(vld_reg))
    `SCR_ASSERT_NXT(a_enter, s_tvalid && s_tready, vld_reg[0])

endmodule

>>> verif/testbench.sv
// self-checking testbench for the 2d static contact resolver
`timescale 1ns / 1ps

module testbench;
    import scr_pkg::*;

    typedef logic signed [127:0] w_t;

    // one contact pair word
    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] dyn [4];
        logic signed [31:0] st [4];
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [16:0]        rest;
    } pair_t;

    // one resolved contact word
    typedef struct {
        logic               hit;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               gnd;
    } contact_t;

    // working values of the resolution, exact until saturation
    typedef struct {
        w_t dx;
        w_t dy;
        w_t vx;
        w_t vy;
        bit hit;
        bit gnd;
    } work_t;

    localparam w_t UNIT = w_t'(1) <<< FRAC_BITS;
    localparam w_t GROUND_NY = ((w_t'(11)) <<< FRAC_BITS) / 20;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [343:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;

    pair_t    pending_pairs [$];
    contact_t expected_contacts [$];
    pair_t    offered;
    int       errors = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_cycles = 0;
    bit       send_paused = 1'b0;

    static_contact_resolver_2d dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // shift right truncating toward zero
    function automatic w_t shr_zero(w_t v, int s);
        w_t m;
        m = (v < 0) ? -v : v;
        m = m >> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic w_t floor_sqrt(w_t v);
        w_t r, c;
        r = 0;
        for (int b = 36; b >= 0; b--) begin
            c = r | (w_t'(1) << b);
            if (c * c <= v) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic w_t clamp_to(w_t c, w_t lo, w_t hi);
        if (c < lo) c = lo;
        if (c > hi) c = hi;
        return c;
    endfunction

    // least penetration face, first one wins on ties
    function automatic logic [1:0] least_face(w_t l, w_t r, w_t d, w_t u, output w_t m);
        logic [1:0] ax;
        ax = AX_LEFT;
        m = l;
        if (r < m) begin m = r; ax = AX_RIGHT; end
        if (d < m) begin m = d; ax = AX_DOWN; end
        if (u < m) begin m = u; ax = AX_UP; end
        return ax;
    endfunction

    // bounce the normal velocity only when approaching
    function automatic void bounce(inout work_t o, input w_t nx, w_t ny, w_t e);
        w_t vn, t;
        vn = shr_zero(o.vx * nx + o.vy * ny, FRAC_BITS);
        if (vn < 0) begin
            t = shr_zero(vn * (65536 + e), 16);
            o.vx = o.vx - shr_zero(t * nx, FRAC_BITS);
            o.vy = o.vy - shr_zero(t * ny, FRAC_BITS);
        end
    endfunction

    function automatic void push_along(inout work_t o, input w_t ux, w_t uy, w_t d,
                                       w_t pen, w_t e);
        w_t nx, ny;
        nx = (ux * UNIT) / d;
        ny = (uy * UNIT) / d;
        o.hit = 1'b1;
        o.dx = shr_zero(nx * pen, FRAC_BITS);
        o.dy = shr_zero(ny * pen, FRAC_BITS);
        bounce(o, nx, ny, e);
        if (ny > GROUND_NY) o.gnd = 1'b1;
    endfunction

    // circle against box; sgn -1 when the box is the moving body
    function automatic void circle_vs_box(inout work_t o, input w_t cx, w_t cy, w_t rad,
                                          w_t b0, w_t b1, w_t b2, w_t b3, w_t sgn, w_t e);
        w_t ux, uy, d2, d, m, pen;
        logic [1:0] ax;
        ux = (cx - clamp_to(cx, b0, b2)) * sgn;
        uy = (cy - clamp_to(cy, b1, b3)) * sgn;
        d2 = ux * ux + uy * uy;
        if (d2 != 0) begin
            d = floor_sqrt(d2);
            pen = rad - d;
            if (pen > 0) push_along(o, ux, uy, d, pen, e);
        end else begin
            ax = least_face(cx - b0, b2 - cx, cy - b1, b3 - cy, m);
            if (m < rad) begin
                pen = rad - m;
                o.hit = 1'b1;
                case (ax)
                    AX_LEFT: begin o.dx = pen; o.vx = 0; end
                    AX_RIGHT: begin o.dx = -pen; o.vx = 0; end
                    AX_DOWN: begin o.dy = pen; o.vy = 0; o.gnd = 1'b1; end
                    default: begin o.dy = -pen; o.vy = 0; end
                endcase
            end
        end
    endfunction

    function automatic logic signed [31:0] clip32(w_t v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // expected contact for one pair
    function automatic contact_t resolve_contact(pair_t p);
        w_t d [4];
        w_t s [4];
        w_t e, l, r, dn, u, m, ux, uy, sum, d2, cdist;
        logic [1:0] ax;
        work_t o;
        contact_t c;
        for (int i = 0; i < 4; i++) begin
            d[i] = p.dyn[i];
            s[i] = p.st[i];
        end
        e = p.rest;
        if (e > 65536) e = 65536;
        o.hit = 1'b0;
        o.gnd = 1'b0;
        o.dx = 0;
        o.dy = 0;
        o.vx = p.vx;
        o.vy = p.vy;
        case (p.cmd)
            CMD_BOX_BOX: begin
                l = d[2] - s[0];
                r = s[2] - d[0];
                dn = d[3] - s[1];
                u = s[3] - d[1];
                if (l > 0 && r > 0 && dn > 0 && u > 0) begin
                    ax = least_face(l, r, dn, u, m);
                    o.hit = 1'b1;
                    case (ax)
                        AX_UP: begin o.dy = u; bounce(o, 0, UNIT, e); o.gnd = 1'b1; end
                        AX_DOWN: begin o.dy = -dn; bounce(o, 0, -UNIT, e); end
                        AX_LEFT: begin o.dx = -l; bounce(o, -UNIT, 0, e); end
                        default: begin o.dx = r; bounce(o, UNIT, 0, e); end
                    endcase
                end
            end
            CMD_BOX_CIR: circle_vs_box(o, s[0], s[1], s[2], d[0], d[1], d[2], d[3], -1, e);
            CMD_CIR_BOX: circle_vs_box(o, d[0], d[1], d[2], s[0], s[1], s[2], s[3], 1, e);
            default: begin
                ux = d[0] - s[0];
                uy = d[1] - s[1];
                sum = d[2] + s[2];
                d2 = ux * ux + uy * uy;
                if (d2 <= sum * sum) begin
                    if (d2 == 0) begin
                        o.hit = 1'b1;
                        o.dx = shr_zero(sum, 1);
                        bounce(o, UNIT, 0, e);
                    end else begin
                        cdist = floor_sqrt(d2);
                        push_along(o, ux, uy, cdist, sum - cdist, e);
                    end
                end
            end
        endcase
        c.hit = o.hit;
        c.gnd = o.hit & o.gnd;
        c.dx = o.hit ? clip32(o.dx) : '0;
        c.dy = o.hit ? clip32(o.dy) : '0;
        c.vx = o.hit ? clip32(o.vx) : '0;
        c.vy = o.hit ? clip32(o.vy) : '0;
        return c;
    endfunction

    task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
        errors++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic pair_t mk(logic [1:0] cmd, int a0, int a1, int a2, int a3, int b0,
                                 int b1, int b2, int b3, int vx, int vy, int rest);
        pair_t p;
        p.cmd = cmd;
        p.dyn = '{a0, a1, a2, a3};
        p.st = '{b0, b1, b2, b3};
        p.vx = vx;
        p.vy = vy;
        p.rest = rest[16:0];
        return p;
    endfunction

    function automatic int around(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // mostly near pairs at random scale, some raw words
    function automatic pair_t random_pair();
        pair_t p;
        int span, w;
        p.cmd = 2'($urandom_range(0, 3));
        p.rest = 17'($urandom_range(0, 131071));
        if ($urandom_range(0, 99) < 10) begin
            for (int i = 0; i < 4; i++) begin
                p.dyn[i] = $urandom;
                p.st[i] = $urandom;
            end
            p.vx = $urandom;
            p.vy = $urandom;
            return p;
        end
        span = 1 << $urandom_range(4, 24);
        p.dyn[0] = around(span << 3);
        p.dyn[1] = around(span << 3);
        p.st[0] = p.dyn[0] + around(span);
        p.st[1] = p.dyn[1] + around(span);
        if ($urandom_range(0, 99) < 4) begin
            p.st[0] = p.dyn[0];
            p.st[1] = p.dyn[1];
        end
        w = int'($urandom_range(0, span));
        p.dyn[2] = (p.cmd == CMD_CIR_BOX || p.cmd == CMD_CIR_CIR) ? w : p.dyn[0] + w;
        w = int'($urandom_range(0, span));
        p.dyn[3] = p.dyn[1] + w;
        w = int'($urandom_range(0, span));
        p.st[2] = (p.cmd == CMD_BOX_CIR || p.cmd == CMD_CIR_CIR) ? w : p.st[0] + w;
        w = int'($urandom_range(0, span));
        p.st[3] = p.st[1] + w;
        if ($urandom_range(0, 99) < 5) begin
            p.dyn[2] = around(span);
            p.st[2] = around(span);
        end
        if ($urandom_range(0, 99) < 30) begin
            p.vx = $urandom;
            p.vy = $urandom;
        end else begin
            p.vx = around(span << 2);
            p.vy = around(span << 2);
        end
        return p;
    endfunction

    // driver: offer pending words, record expectations on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_contacts.push_back(resolve_contact(offered));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_pairs.size() > 0 && !send_paused &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    offered = pending_pairs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= offered.cmd;
                    s_tdata <= {7'd0, offered.rest, offered.vy, offered.vx,
                                offered.st[3], offered.st[2], offered.st[1], offered.st[0],
                                offered.dyn[3], offered.dyn[2], offered.dyn[1],
                                offered.dyn[0]};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result word against the oldest expectation
    always @(posedge aclk) begin
        contact_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_contacts.size() == 0) begin
                    report("unexpected word", m_tdata[32:1], 0);
                end else begin
                    want = expected_contacts.pop_front();
                    if (m_tdata[0] !== want.hit) report("hit", m_tdata[0], want.hit);
                    if (m_tdata[32:1] !== want.dx) report("delta_x", m_tdata[32:1], want.dx);
                    if (m_tdata[64:33] !== want.dy) report("delta_y", m_tdata[64:33], want.dy);
                    if (m_tdata[96:65] !== want.vx) report("new_vel_x", m_tdata[96:65], want.vx);
                    if (m_tdata[128:97] !== want.vy)
                        report("new_vel_y", m_tdata[128:97], want.vy);
                    if (m_tdata[129] !== want.gnd) report("grounded", m_tdata[129], want.gnd);
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic drain();
        while (pending_pairs.size() > 0 || s_tvalid || expected_contacts.size() > 0) begin
            @(negedge aclk);
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed pairs: each face, ties, touching, inside faces, extremes
        pending_pairs.push_back(mk(CMD_BOX_BOX, 0, 0, 'h40000, 'h40000, 'h38000, 'h8000,
                                   'h80000, 'h38000, 'h10000, -'h10000, 'h8000));
        pending_pairs.push_back(mk(CMD_BOX_BOX, 'h38000, 'h8000, 'h80000, 'h38000, 0, 0,
                                   'h40000, 'h40000, -'h20000, 5, 'h1ffff));
        pending_pairs.push_back(mk(CMD_BOX_BOX, 0, 'h38000, 'h40000, 'h80000, -'h8000,
                                   0, 'h48000, 'h40000, 3, -'h30000, 0));
        pending_pairs.push_back(mk(CMD_BOX_BOX, 0, 0, 'h40000, 'h40000, -'h8000, 'h38000,
                                   'h48000, 'h80000, 7, 'h30000, 'h10000));
        pending_pairs.push_back(mk(CMD_BOX_BOX, 0, 0, 10, 10, 5, 5, 15, 15, 1, 1, 'h10000));
        pending_pairs.push_back(mk(CMD_BOX_BOX, 0, 0, 10, 10, 10, 0, 20, 10, 1, 1, 0));
        pending_pairs.push_back(mk(CMD_BOX_BOX, 10, 10, 0, 0, 0, 0, 10, 10, 1, 1, 0));
        pending_pairs.push_back(mk(CMD_CIR_BOX, 'h8000, 'h10000, 'h20000, 0, 0, 0,
                                   'h100000, 'h100000, -'h10000, 0, 'h8000));
        pending_pairs.push_back(mk(CMD_CIR_BOX, 'hf8000, 'h80000, 'h20000, 0, 0, 0,
                                   'h100000, 'h100000, 'h10000, 9, 'h8000));
        pending_pairs.push_back(mk(CMD_CIR_BOX, 'h80000, 'h8000, 'h20000, 0, 0, 0,
                                   'h100000, 'h100000, 9, -'h10000, 'h8000));
        pending_pairs.push_back(mk(CMD_CIR_BOX, 'h80000, 'hf8000, 'h20000, 0, 0, 0,
                                   'h100000, 'h100000, 9, 'h10000, 'h8000));
        pending_pairs.push_back(mk(CMD_CIR_BOX, 'h80000, 'h80000, 'h10000, 0, 0, 0,
                                   'h100000, 'h100000, 1, 1, 0));
        pending_pairs.push_back(mk(CMD_CIR_BOX, 'h118000, 'h110000, 'h20000, 0, 0, 0,
                                   'h100000, 'h100000, -'h10000, -'h10000, 'h10000));
        pending_pairs.push_back(mk(CMD_CIR_BOX, 'h80000, 'h108000, 'h20000, 0, 0, 0,
                                   'h100000, 'h100000, 3, -'h40000, 'h18000));
        pending_pairs.push_back(mk(CMD_BOX_CIR, 0, 0, 'h100000, 'h100000, 'h80000,
                                   'h108000, 'h20000, 0, 'h10000, 'h10000, 'h4000));
        pending_pairs.push_back(mk(CMD_BOX_CIR, 0, 0, 'h100000, 'h100000, 'h80000,
                                   'h80000, 'h20000, 0, 'h10000, 'h10000, 'h4000));
        pending_pairs.push_back(mk(CMD_CIR_CIR, 5, 5, 'h30001, 0, 5, 5, 'h20000, 0,
                                   -'h10000, 4, 'hc000));
        pending_pairs.push_back(mk(CMD_CIR_CIR, 'h10000, 'h30000, 'h20000, 0, 0, 0,
                                   'h20000, 0, 0, -'h50000, 'h10000));
        pending_pairs.push_back(mk(CMD_CIR_CIR, 0, 'h40000, 'h20000, 0, 0, 0, 'h20000, 0,
                                   1, -1, 0));
        pending_pairs.push_back(mk(CMD_CIR_CIR, 0, 0, -'h20000, 0, 'h8000, 0, -'h10000, 0,
                                   1, 1, 0));
        pending_pairs.push_back(mk(CMD_CIR_CIR, 'h80000000, 'h80000000, 'h7fffffff,
                                   'h7fffffff, 'h7fffffff, 'h7fffffff, 'h7fffffff,
                                   'h7fffffff, 'h80000000, 'h80000000, 'h1ffff));
        pending_pairs.push_back(mk(CMD_BOX_BOX, 'h80000000, 'h80000000, 'h7fffffff,
                                   'h7fffffff, 'h80000000, 'h80000000, 'h7fffffff,
                                   'h7fffffff, 'h7fffffff, 'h80000000, 'h1ffff));
        pending_pairs.push_back(mk(CMD_CIR_BOX, 'h7fffffff, 'h80000000, 'h7fffffff, 0,
                                   'h80000000, 'h7fffffff, 'h80000000, 'h7fffffff,
                                   'h80000000, 'h7fffffff, 'h10001));
        pending_pairs.push_back(mk(CMD_BOX_CIR, -1, -1, -1, -1, 0, 0, 0, 0, -1, -1, 0));
        drain();

        // four phases: no idling, sender idling, receiver stalls, both; the first one also holds the receiver off
        for (int ph = 0; ph < 4; ph++) begin
            @(negedge aclk);
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 36) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 74 : 36) : 0;
            for (int i = 0; i < 388; i++) begin
                pending_pairs.push_back(random_pair());
            end
            if (ph == 0) begin
                hold_cycles = 300;
            end
            if (ph == 2) begin
                // sender stops midway until all results are back
                while (pending_pairs.size() > 200) @(negedge aclk);
                send_paused = 1'b1;
                while (s_tvalid || expected_contacts.size() > 0) @(negedge aclk);
                send_paused = 1'b0;
            end
            drain();
        end

        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("** static_contact_resolver_2d: PASSED **");
        end else begin
            $display("** static_contact_resolver_2d: FAILED **");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("** static_contact_resolver_2d: FAILED **");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/scr_pkg.sv
hdl/static_contact_resolver_2d.sv
verif/testbench.sv
